### rtl/core/awma_pkg.sv
// ----------------------------------------------------------------------------
// awma_pkg
// shared types and constants of the angle wrap moving average
// ----------------------------------------------------------------------------
package awma_pkg;

  localparam int unsigned ANGLE_W          = 9;
  localparam int unsigned USED_W           = 3;
  localparam int unsigned WINDOW_DEPTH_DEF = 5;

  // wrap thresholds in degrees
  localparam int unsigned FULL_TURN  = 360;
  localparam int unsigned HALF_TURN  = 180;
  localparam int unsigned LOW_BAND   = 90;
  localparam int unsigned HIGH_BAND  = 270;
  localparam int unsigned ANGLE_MAX  = 511;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_sample;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] smoothed_angle;
    logic [USED_W-1:0]  entries_used;
  } out_item_t;

  // datapath commands issued by the sequencer
  typedef struct packed {
    logic clear;
    logic accum;
    logic lift;
    logic div_step;
  } dp_ctrl_t;

endpackage

### rtl/core/angle_wrap_moving_average_top.sv
// ----------------------------------------------------------------------------
// angle_wrap_moving_average_top
// circular moving average of heading samples over a short window
// ----------------------------------------------------------------------------
// Each transfer on the input brings one heading sample in degrees and a
// restart flag that empties the window first. The sample is pushed into a
// window of WindowDepth entries and one result transfer follows with the
// wrapped average and the number of entries averaged. When the window holds
// values near both ends of the circle, values below 180 are lifted by 360
// before the average, and the result is folded back below 360. An item passes
// through these steps in order: the transfer, one accumulate pass per window
// entry through the shared adder, a lift step, one restoring divide step per
// sum bit (SumW = 13 at depth five), and the load of the output register,
// which waits until the previous result has gone. The output register lets
// the next sample be taken while a result still waits downstream.
// ----------------------------------------------------------------------------
module angle_wrap_moving_average_top #(
  parameter int unsigned WindowDepth = awma_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  awma_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output awma_pkg::out_item_t out_data_o
);
  import awma_pkg::*;

  localparam int unsigned CntW  = $clog2(WindowDepth + 1);
  localparam int unsigned IdxW  = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
  localparam int unsigned SumW  = $clog2(WindowDepth * (ANGLE_MAX + FULL_TURN) + 1);
  localparam int unsigned DivCW = $clog2(SumW);
  localparam int unsigned ExtW  = (CntW > USED_W) ? CntW : USED_W;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ACC  = 5'b00010,
    S_LIFT = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [DivCW-1:0] div_cnt_q, div_cnt_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  dp_ctrl_t         ctrl;
  logic             in_xfer;
  logic [ANGLE_W-1:0] entry;
  logic [ANGLE_W-1:0] avg;
  logic [CntW-1:0]    count;
  logic [ExtW-1:0]    count_ext;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign count_ext  = ExtW'(count);

  // window store, pushed on the input transfer
  awma_window #(
    .WindowDepth(WindowDepth)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_xfer),
    .restart_i (in_data_i.restart),
    .sample_i  (in_data_i.angle_sample),
    .rd_idx_i  (idx_q),
    .rd_data_o (entry),
    .count_o   (count)
  );

  // shared arithmetic unit
  awma_arith #(
    .WindowDepth(WindowDepth)
  ) u_arith (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .entry_i (entry),
    .count_i (count),
    .avg_o   (avg)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    div_cnt_d   = div_cnt_q;
    ctrl        = '0;
    out_d       = out_q;
    // result leaves on its transfer
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          // clear accumulator while the window takes the sample
          ctrl.clear = 1'b1;
          idx_d      = '0;
          state_d    = S_ACC;
        end
      end
      S_ACC: begin
        // one window entry per cycle, newest first
        ctrl.accum = 1'b1;
        if (CntW'(idx_q) + CntW'(1) == count) begin
          state_d = S_LIFT;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_LIFT: begin
        ctrl.lift = 1'b1;
        div_cnt_d = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        // one quotient bit per cycle
        ctrl.div_step = 1'b1;
        if (div_cnt_q == DivCW'(SumW - 1)) begin
          state_d = S_DONE;
        end else begin
          div_cnt_d = div_cnt_q + DivCW'(1);
        end
      end
      S_DONE: begin
        // load output register once the previous result has gone
        if (!out_valid_q || out_ready_i) begin
          out_d.smoothed_angle = avg;
          out_d.entries_used   = count_ext[USED_W-1:0];
          out_valid_d          = 1'b1;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a transfer always starts the accumulate pass
  a_xfer_starts_acc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == S_ACC)
    else $error("input transfer did not start accumulation");

  // the window is never empty while it is being summed
  a_acc_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ACC |-> count != '0)
    else $error("accumulating an empty window");

  // after the single wrap the average always lies below a full turn
  a_result_wrapped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.smoothed_angle < ANGLE_W'(FULL_TURN))
    else $error("smoothed angle not wrapped");

  // a result always reports at least one entry when the count fits the field
  a_used_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (WindowDepth >= (1 << USED_W)) || (out_data_o.entries_used != '0))
    else $error("result reports an empty window");

endmodule

### rtl/core/awma_window.sv
// ----------------------------------------------------------------------------
// awma_window
// sample window shift line with fill count and one indexed read port
// ----------------------------------------------------------------------------
module awma_window #(
  parameter int unsigned WindowDepth = awma_pkg::WINDOW_DEPTH_DEF,
  localparam int unsigned CntW = $clog2(WindowDepth + 1),
  localparam int unsigned IdxW = (WindowDepth > 1) ? $clog2(WindowDepth) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic                         restart_i,
  input  logic [awma_pkg::ANGLE_W-1:0] sample_i,
  input  logic [IdxW-1:0]              rd_idx_i,
  output logic [awma_pkg::ANGLE_W-1:0] rd_data_o,
  output logic [CntW-1:0]              count_o
);
  import awma_pkg::*;

  logic [ANGLE_W-1:0] entries_q [WindowDepth];
  logic [CntW-1:0]    count_q, count_d, count_base;

  // newest at the front, oldest falls off the end
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      for (int i = WindowDepth - 1; i > 0; i--) begin
        entries_q[i] <= entries_q[i-1];
      end
      entries_q[0] <= sample_i;
    end
  end

  always_comb begin
    count_base = restart_i ? '0 : count_q;
    count_d    = count_q;
    if (push_i) begin
      count_d = (count_base < CntW'(WindowDepth)) ? count_base + CntW'(1) : count_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign rd_data_o = entries_q[rd_idx_i];
  assign count_o   = count_q;

endmodule

### rtl/core/awma_arith.sv
// ----------------------------------------------------------------------------
// awma_arith
// shared accumulate, lift and restoring divide unit
// ----------------------------------------------------------------------------
module awma_arith #(
  parameter int unsigned WindowDepth = awma_pkg::WINDOW_DEPTH_DEF,
  localparam int unsigned CntW = $clog2(WindowDepth + 1),
  localparam int unsigned SumW = $clog2(WindowDepth *
                                        (awma_pkg::ANGLE_MAX + awma_pkg::FULL_TURN) + 1)
) (
  input  logic                         clk_i,
  input  awma_pkg::dp_ctrl_t           ctrl_i,
  input  logic [awma_pkg::ANGLE_W-1:0] entry_i,
  input  logic [CntW-1:0]              count_i,
  output logic [awma_pkg::ANGLE_W-1:0] avg_o
);
  import awma_pkg::*;

  // sum register doubles as dividend / quotient shift register
  logic [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic [CntW-1:0] nlow_q, nlow_d;
  logic            lo_q, lo_d, hi_q, hi_d;
  logic [CntW:0]   partial, trial;
  logic            fits;
  logic [SumW-1:0] wrapped;

  always_comb begin
    partial = {rem_q, sum_q[SumW-1]};
    trial   = partial - {1'b0, count_i};
    fits    = (partial >= {1'b0, count_i});
    sum_d   = sum_q;
    rem_d   = rem_q;
    nlow_d  = nlow_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    if (ctrl_i.clear) begin
      sum_d  = '0;
      nlow_d = '0;
      lo_d   = 1'b0;
      hi_d   = 1'b0;
    end else if (ctrl_i.accum) begin
      sum_d = sum_q + SumW'(entry_i);
      if (entry_i < ANGLE_W'(HALF_TURN)) begin
        nlow_d = nlow_q + CntW'(1);
      end
      if (entry_i < ANGLE_W'(LOW_BAND)) begin
        lo_d = 1'b1;
      end else if (entry_i > ANGLE_W'(HIGH_BAND)) begin
        hi_d = 1'b1;
      end
    end else if (ctrl_i.lift) begin
      // lifting every value below half a turn adds one full turn per such value
      if (lo_q && hi_q) begin
        sum_d = sum_q + SumW'(nlow_q) * SumW'(FULL_TURN);
      end
      rem_d = '0;
    end else if (ctrl_i.div_step) begin
      sum_d = {sum_q[SumW-2:0], fits};
      rem_d = fits ? trial[CntW-1:0] : partial[CntW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    rem_q  <= rem_d;
    nlow_q <= nlow_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
  end

  // single wrap of the quotient
  assign wrapped = (sum_q >= SumW'(FULL_TURN)) ? sum_q - SumW'(FULL_TURN) : sum_q;
  assign avg_o   = wrapped[ANGLE_W-1:0];

endmodule
